/* hdl/cmq_pkg.sv */
package cmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [7:0] TYPE_EMPTY = 8'd0;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  msg_type;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_in_item;

    typedef struct packed {
        logic        got_message;
        logic [7:0]  out_type;
        logic [15:0] out_word_a;
        logic [15:0] out_word_b;
        logic        push_dropped;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_entry;

    // slot array command: shift all forward, then optional write
    typedef struct packed {
        logic shift;
        logic write;
    } t_store_cmd;

endpackage

/* hdl/compacting_message_queue.sv */
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------
// request   | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
// result    | out       | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//
// Push, pop and clear load the result register at the edge that accepts the
// request. Remove-by-type rotates the queue through slot 0 one entry per
// cycle past a single type comparator. Reset (i_rst_n low, synchronous)
// empties the queue at once. A new request is taken only while no remove is
// running and the result register is empty or being drained; a stalled
// result holds its value.
module compacting_message_queue #(
    parameter int QUEUE_DEPTH = cmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cmq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cmq_pkg::t_out_item o_out_data
);
    import cmq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);

    // sequencer -> slot array
    t_store_cmd    cmd;
    logic [IW-1:0] wr_idx;
    t_entry        wr_data;
    // slot 0, seen by pop and by the remove comparator
    t_entry        head;

    // Sequencer: holds the occupancy count, runs the remove pass and owns
    // the result register. Entries stay packed from slot 0, so the count
    // alone says which slots are live.
    cmq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head      (head),
        .o_cmd       (cmd),
        .o_wr_idx    (wr_idx),
        .o_wr_data   (wr_data)
    );

    // Slot array: a shift line (pop and rotate) with one write port for
    // push and for re-appending kept entries at the tail.
    cmq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .o_head    (head)
    );

endmodule

/* hdl/cmq_store.sv */
module cmq_store #(
    parameter int QUEUE_DEPTH = cmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  cmq_pkg::t_store_cmd                i_cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]     i_wr_idx,
    input  cmq_pkg::t_entry                    i_wr_data,
    output cmq_pkg::t_entry                    o_head
);
    import cmq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);

    t_entry r_slot [QUEUE_DEPTH];
    t_entry n_slot [QUEUE_DEPTH];

    // shift first, write lands on the shifted array
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.shift && (i < QUEUE_DEPTH - 1)) begin
                n_slot[i] = r_slot[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (i_cmd.write && (i_wr_idx == IW'(i))) begin
                n_slot[i] = i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    assign o_head = r_slot[0];

endmodule

/* hdl/cmq_seq.sv */
module cmq_seq #(
    parameter int QUEUE_DEPTH = cmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  cmq_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output cmq_pkg::t_out_item                 o_out_data,
    input  cmq_pkg::t_entry                    i_head,
    output cmq_pkg::t_store_cmd                o_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_wr_idx,
    output cmq_pkg::t_entry                    o_wr_data
);
    import cmq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REMOVE = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic [7:0]    r_rm_type, n_rm_type;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_out, n_out;
    logic          in_fire;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_ovalid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_rm_type = r_rm_type;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_out     = r_out;
        o_cmd     = '0;
        o_wr_idx  = '0;
        o_wr_data = i_head;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_out    = '0;
                    n_ovalid = 1'b1;
                    unique case (i_in_data.func)
                        OP_PUSH: begin
                            if (i_in_data.msg_type != TYPE_EMPTY) begin
                                if (r_cnt == CW'(QUEUE_DEPTH)) begin
                                    n_out.push_dropped = 1'b1;
                                end else begin
                                    o_cmd.write       = 1'b1;
                                    o_wr_idx          = r_cnt[IW-1:0];
                                    o_wr_data.msg_type = i_in_data.msg_type;
                                    o_wr_data.word_a  = i_in_data.word_a;
                                    o_wr_data.word_b  = i_in_data.word_b;
                                    n_cnt             = r_cnt + CW'(1);
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_cnt != '0) begin
                                n_out.got_message = 1'b1;
                                n_out.out_type    = i_head.msg_type;
                                n_out.out_word_a  = i_head.word_a;
                                n_out.out_word_b  = i_head.word_b;
                                o_cmd.shift       = 1'b1;
                                n_cnt             = r_cnt - CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if ((i_in_data.msg_type != TYPE_EMPTY) && (r_cnt != '0)) begin
                                n_ovalid  = 1'b0;
                                n_state   = ST_REMOVE;
                                n_left    = r_cnt;
                                n_rm_type = i_in_data.msg_type;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                            n_cnt = r_cnt;
                        end
                    endcase
                end
            end
            ST_REMOVE: begin
                // rotate head to the tail if kept, drop it otherwise
                o_cmd.shift = 1'b1;
                if (i_head.msg_type != r_rm_type) begin
                    o_cmd.write = 1'b1;
                    o_wr_idx    = IW'(r_cnt - CW'(1));
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                    n_out    = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rm_type <= n_rm_type;
        r_out     <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

/* hdl/cmq_checker.sv */
module cmq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input cmq_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cmq_pkg::t_out_item o_out_data
);
    import cmq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no new request while a result is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken with result pending");

    // push, pop and clear produce their result next cycle
    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.func != OP_REMOVE) |=> o_out_valid)
        else $error("missing result for single-cycle request");

    // only a pop yields a message; a remove pass shows no result yet
    a_pop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.func != OP_POP)
        |=> !o_out_valid ||
            (!o_out_data.got_message && (o_out_data.out_type == TYPE_EMPTY)))
        else $error("message reported for non-pop request");

endmodule

bind compacting_message_queue cmq_checker u_cmq_checker (.*);
